[design/bsvc_pkg.sv]
// package for the banded step valve controller
// types, register map, speed and action codes, divide-by-100 constants; no dependencies
package bsvc_pkg;

    // speed band codes
    localparam logic [2:0] SPD_IDLE   = 3'd0;
    localparam logic [2:0] SPD_HALT   = 3'd1;
    localparam logic [2:0] SPD_SLOW   = 3'd2;
    localparam logic [2:0] SPD_MEDIUM = 3'd3;
    localparam logic [2:0] SPD_FAST   = 3'd4;

    // request kinds
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_MANUAL = 2'd1;
    localparam logic [1:0] ACT_CLOSE  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_TARGET_FLOW    = 3'd0;
    localparam logic [2:0] REG_AUTO_ENABLE    = 3'd1;
    localparam logic [2:0] REG_HALT_BAND      = 3'd2;
    localparam logic [2:0] REG_MEDIUM_BAND    = 3'd3;
    localparam logic [2:0] REG_FAST_BAND      = 3'd4;
    localparam logic [2:0] REG_STEP_SIZE      = 3'd5;
    localparam logic [2:0] REG_TRAVEL_TIME_MS = 3'd6;
    localparam logic [2:0] REG_REVERSE_SENSE  = 3'd7;

    localparam logic [6:0]  POS_MAX      = 7'd100;
    localparam logic [7:0]  TICKS_MAX    = 8'd255;
    localparam logic [15:0] TRAVEL_RESET = 16'd4000;
    localparam logic [6:0]  STEP_RESET   = 7'd1;

    // x / 100 == (x * DIV100_RECIP) >> DIV100_SHIFT, exact for x < 2^23
    localparam int          DIV100_SHIFT = 30;
    localparam logic [23:0] DIV100_RECIP = 24'd10737419;

    typedef struct packed {
        logic [15:0] target_flow;
        logic        auto_enable;
        logic [15:0] halt_band;
        logic [15:0] medium_band;
        logic [15:0] fast_band;
        logic [6:0]  step_size;
        logic [15:0] travel_time_ms;
        logic        reverse_sense;
    } cfg_t;

    typedef struct packed {
        logic [6:0] valve_position;
        logic [7:0] in_band_count;
        logic [7:0] ticks_since_step;
        logic [2:0] current_speed;
    } state_t;

    typedef struct packed {
        logic [6:0] position;
        logic [2:0] speed_band;
        logic       locked;
        logic       move;
        logic       opening;
        logic [6:0] change;
    } step_res_t;

endpackage

[design/bsvc_step.sv]
// next-state and result logic for one request of the valve controller
// depends on bsvc_pkg
module bsvc_step #(
    parameter logic [7:0] FAST_PACE    = 8'd1,
    parameter logic [7:0] MEDIUM_PACE  = 8'd3,
    parameter logic [7:0] SLOW_PACE    = 8'd8,
    parameter logic [7:0] LOCK_CONFIRM = 8'd5
) (
    input  bsvc_pkg::cfg_t      cfg,
    input  bsvc_pkg::state_t    st,
    input  logic [1:0]          action,
    input  logic [15:0]         flow_sample,
    input  logic                link_ok,
    input  logic [6:0]          requested_position,
    output bsvc_pkg::state_t    st_next,
    output bsvc_pkg::step_res_t res
);
    import bsvc_pkg::*;

    logic        pos_err;
    logic [15:0] mag;
    logic [7:0]  ticks_inc;
    logic [7:0]  pace;
    logic [2:0]  band;
    logic        up;
    logic [7:0]  up_sum;
    logic [6:0]  step_pos;
    logic [6:0]  manual_pos;
    logic [6:0]  goal;
    logic        do_goto;

    always_comb begin
        pos_err   = cfg.target_flow > flow_sample;
        mag       = pos_err ? (cfg.target_flow - flow_sample) : (flow_sample - cfg.target_flow);
        ticks_inc = (st.ticks_since_step < TICKS_MAX) ? (st.ticks_since_step + 8'd1)
                                                      : st.ticks_since_step;
        if (mag > cfg.fast_band) begin
            band = SPD_FAST;
            pace = FAST_PACE;
        end else if (mag > cfg.medium_band) begin
            band = SPD_MEDIUM;
            pace = MEDIUM_PACE;
        end else begin
            band = SPD_SLOW;
            pace = SLOW_PACE;
        end
        up       = pos_err != cfg.reverse_sense;
        up_sum   = {1'b0, st.valve_position} + {1'b0, cfg.step_size};
        if (up) begin
            step_pos = (up_sum > {1'b0, POS_MAX}) ? POS_MAX : up_sum[6:0];
        end else begin
            step_pos = (cfg.step_size >= st.valve_position) ? 7'd0
                                                            : (st.valve_position - cfg.step_size);
        end
        manual_pos = (requested_position > POS_MAX) ? POS_MAX : requested_position;
    end

    always_comb begin
        st_next     = st;
        goal        = st.valve_position;
        do_goto     = 1'b0;
        res.move    = 1'b0;
        res.opening = 1'b0;
        res.change  = 7'd0;
        case (action)
            ACT_TICK: begin
                if (!cfg.auto_enable || !link_ok) begin
                    st_next.current_speed = SPD_IDLE;
                end else begin
                    st_next.ticks_since_step = ticks_inc;
                    if (mag <= cfg.halt_band) begin
                        st_next.current_speed = SPD_HALT;
                        if (st.in_band_count < LOCK_CONFIRM) begin
                            st_next.in_band_count = st.in_band_count + 8'd1;
                        end
                    end else begin
                        st_next.in_band_count = 8'd0;
                        st_next.current_speed = band;
                        if (ticks_inc >= pace) begin
                            st_next.ticks_since_step = 8'd0;
                            goal    = step_pos;
                            do_goto = 1'b1;
                        end
                    end
                end
            end
            ACT_MANUAL: begin
                goal    = manual_pos;
                do_goto = 1'b1;
            end
            ACT_CLOSE: begin
                // full travel always, even when already closed
                st_next.valve_position = 7'd0;
                res.move   = 1'b1;
                res.change = POS_MAX;
            end
            default: begin
            end
        endcase

        if (do_goto && goal != st.valve_position) begin
            res.move               = 1'b1;
            res.opening            = goal > st.valve_position;
            res.change             = (goal > st.valve_position) ? (goal - st.valve_position)
                                                                : (st.valve_position - goal);
            st_next.valve_position = goal;
        end

        res.position   = st_next.valve_position;
        res.speed_band = st_next.current_speed;
        res.locked     = cfg.auto_enable && (st_next.in_band_count >= LOCK_CONFIRM);
    end

endmodule

[design/banded_step_valve_controller_unit.sv]
// top level of the banded step valve controller: apb registers, state, two-stage pipeline
// depends on bsvc_pkg and bsvc_step

// The controller tracks a valve opening of 0..100 percent and answers every
// request with exactly one result. A request's kind travels in s_tuser: a
// control tick (uses flow sample and link flag), a manual position request
// (saturated to 100) or a force close. Results carry position, speed band,
// lock, move, direction and the drive time |change| * travel_time_ms / 100.
// One request is taken every clock cycle while the result side keeps up; a
// result passes through the stage-one register and then the result register,
// where it is presented and held until taken. With the result side stalled the
// two stages hold two requests and s_tready drops. Stage one updates the valve
// state and forms the product of the position change and the full travel
// time; stage two divides that product by 100 through a reciprocal multiply
// into the result register.
// Registers sit on an apb port at byte address 4*index and must be written
// only while no request is in flight; writing target_flow or auto_enable
// clears the lock and pacing counters.
module banded_step_valve_controller_unit #(
    parameter logic [7:0] FAST_PACE    = 8'd1,
    parameter logic [7:0] MEDIUM_PACE  = 8'd3,
    parameter logic [7:0] SLOW_PACE    = 8'd8,
    parameter logic [7:0] LOCK_CONFIRM = 8'd5
) (
    input  logic        aclk,
    input  logic        aresetn,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // flow_sample[15:0], link_ok[16], requested_position[23:17]
    input  logic [1:0]  s_tuser,   // action[1:0]

    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // position[6:0], speed_band[9:7], locked[10], move[11],
                                   // opening[12], run_time_ms[28:13], zero[31:29]
);
    import bsvc_pkg::*;

    cfg_t      cfg_reg;
    state_t    st_reg;
    state_t    st_next;
    step_res_t step_res;

    // stage one: state result and run-time product
    logic        mid_valid_reg;
    step_res_t   mid_res_reg;
    logic [22:0] mid_prod_reg;

    // stage two: result register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic        s_accept;
    logic        mid_adv;
    logic [46:0] recip_prod;
    logic [15:0] run_time;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    // register readback
    always_comb begin
        prdata = 32'd0;
        case (cfg_index)
            REG_TARGET_FLOW:    prdata = {16'd0, cfg_reg.target_flow};
            REG_AUTO_ENABLE:    prdata = {31'd0, cfg_reg.auto_enable};
            REG_HALT_BAND:      prdata = {16'd0, cfg_reg.halt_band};
            REG_MEDIUM_BAND:    prdata = {16'd0, cfg_reg.medium_band};
            REG_FAST_BAND:      prdata = {16'd0, cfg_reg.fast_band};
            REG_STEP_SIZE:      prdata = {25'd0, cfg_reg.step_size};
            REG_TRAVEL_TIME_MS: prdata = {16'd0, cfg_reg.travel_time_ms};
            REG_REVERSE_SENSE:  prdata = {31'd0, cfg_reg.reverse_sense};
            default:            prdata = 32'd0;
        endcase
    end

    // pipeline flow control: each stage moves when the one after it has room
    assign mid_adv  = mid_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !mid_valid_reg || mid_adv;
    assign s_accept = s_tvalid && s_tready;

    bsvc_step #(
        .FAST_PACE    (FAST_PACE),
        .MEDIUM_PACE  (MEDIUM_PACE),
        .SLOW_PACE    (SLOW_PACE),
        .LOCK_CONFIRM (LOCK_CONFIRM)
    ) u_step (
        .cfg                (cfg_reg),
        .st                 (st_reg),
        .action             (s_tuser),
        .flow_sample        (s_tdata[15:0]),
        .link_ok            (s_tdata[16]),
        .requested_position (s_tdata[23:17]),
        .st_next            (st_next),
        .res                (step_res)
    );

    // configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_flow    <= 16'd0;
            cfg_reg.auto_enable    <= 1'b0;
            cfg_reg.halt_band      <= 16'd0;
            cfg_reg.medium_band    <= 16'd0;
            cfg_reg.fast_band      <= 16'd0;
            cfg_reg.step_size      <= STEP_RESET;
            cfg_reg.travel_time_ms <= TRAVEL_RESET;
            cfg_reg.reverse_sense  <= 1'b0;
            st_reg.valve_position   <= 7'd0;
            st_reg.in_band_count    <= 8'd0;
            st_reg.ticks_since_step <= 8'd0;
            st_reg.current_speed    <= SPD_IDLE;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_TARGET_FLOW: begin
                    cfg_reg.target_flow     <= pwdata[15:0];
                    st_reg.in_band_count    <= 8'd0;
                    st_reg.ticks_since_step <= 8'd0;
                end
                REG_AUTO_ENABLE: begin
                    cfg_reg.auto_enable     <= pwdata[0];
                    st_reg.in_band_count    <= 8'd0;
                    st_reg.ticks_since_step <= 8'd0;
                    if (!pwdata[0]) begin
                        st_reg.current_speed <= SPD_IDLE;
                    end
                end
                REG_HALT_BAND:      cfg_reg.halt_band      <= pwdata[15:0];
                REG_MEDIUM_BAND:    cfg_reg.medium_band    <= pwdata[15:0];
                REG_FAST_BAND:      cfg_reg.fast_band      <= pwdata[15:0];
                REG_STEP_SIZE:      cfg_reg.step_size      <= pwdata[6:0];
                REG_TRAVEL_TIME_MS: cfg_reg.travel_time_ms <= pwdata[15:0];
                REG_REVERSE_SENSE:  cfg_reg.reverse_sense  <= pwdata[0];
                default: begin
                end
            endcase
        end else if (s_accept) begin
            st_reg <= st_next;
        end
    end

    // stage one valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (s_tready) begin
            mid_valid_reg <= s_tvalid;
        end
    end

    // stage one payload: change times full travel, at most 100 * 65535
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mid_res_reg  <= step_res;
            mid_prod_reg <= {16'd0, step_res.change} * {7'd0, cfg_reg.travel_time_ms};
        end
    end

    // divide by 100 via reciprocal
    assign recip_prod = {24'd0, mid_prod_reg} * {23'd0, DIV100_RECIP};
    assign run_time   = recip_prod[DIV100_SHIFT +: 16];

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mid_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv) begin
            out_data_reg <= {3'd0, run_time, mid_res_reg.opening, mid_res_reg.move,
                             mid_res_reg.locked, mid_res_reg.speed_band, mid_res_reg.position};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
